>>> src/cnl_pkg.sv
// shared constants and types for the comparator network layering block
`timescale 1ns / 1ps

package cnl_pkg;

  localparam int MAX_LAYERS_DEF = 64;
  localparam int WIRE_COUNT_DEF = 64;

  // field widths fixed by the interface
  localparam int WIRE_W  = 6;
  localparam int LAYER_W = 6;
  localparam int DEPTH_W = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } cnl_state_t;

endpackage

>>> src/comparator_network_layering_top.sv
// top level of the greedy comparator layering block
`timescale 1ns / 1ps

// channel   | signals                                        | direction
// ----------+------------------------------------------------+----------
// input     | in_valid, in_ready, wire_low, wire_high,       | in
//           | first_of_network                               |
// output    | out_valid, out_ready, assigned_layer,          | out
//           | network_depth, layer_overflow                  |
//
// one comparator is handled at a time: it is accepted in ST_IDLE, then the
// layers are scanned in ST_SCAN downward from the newest (none when no layer is
// open, else at least one and at most the number of open layers), then the
// result is committed in ST_COMMIT
// the scan is set by the single read port of the mask memory, one layer a cycle
// reset clears the layer count but not the masks; entries at or above the count
// go unused and a new layer is written whole, so no clearing pass is needed
// the commit holds while an earlier result still waits in the output register

module comparator_network_layering_top #(
  parameter int MAX_LAYERS = cnl_pkg::MAX_LAYERS_DEF,
  parameter int WIRE_COUNT = cnl_pkg::WIRE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cnl_pkg::WIRE_W-1:0]   wire_low,
  input  logic [cnl_pkg::WIRE_W-1:0]   wire_high,
  input  logic                         first_of_network,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cnl_pkg::LAYER_W-1:0]  assigned_layer,
  output logic [cnl_pkg::DEPTH_W-1:0]  network_depth,
  output logic                         layer_overflow
);

  localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CW = $clog2(MAX_LAYERS + 1);
  localparam int WW = (WIRE_COUNT > 1) ? $clog2(WIRE_COUNT) : 1;

  cnl_pkg::cnl_state_t state, state_next;

  logic [CW-1:0]         count, count_next;
  logic [LW-1:0]         ptr, ptr_next;
  logic [CW-1:0]         tgt, tgt_next;
  logic [WIRE_COUNT-1:0] prev, prev_next;
  logic [WIRE_COUNT-1:0] wmask, wmask_next;
  logic [WIRE_COUNT-1:0] occ, occ_q;

  logic [LW-1:0]         rd_addr;
  logic [WIRE_COUNT-1:0] rd_data;
  logic                  wr_en;
  logic                  out_load;
  logic                  ovf;
  logic                  is_new;
  logic                  hit;
  logic [CW-1:0]         count_eff;
  logic [WW-1:0]         lo_c, hi_c;

  // wire indices past the last wire saturate to the last wire
  always_comb begin
    if ({1'b0, wire_low} >= (cnl_pkg::WIRE_W + 1)'(WIRE_COUNT)) begin
      lo_c = WW'(WIRE_COUNT - 1);
    end else begin
      lo_c = WW'(wire_low);
    end
    if ({1'b0, wire_high} >= (cnl_pkg::WIRE_W + 1)'(WIRE_COUNT)) begin
      hi_c = WW'(WIRE_COUNT - 1);
    end else begin
      hi_c = WW'(wire_high);
    end
  end

  // occupancy of the comparator, two bits set, a single bit when both wires match
  assign occ = ({{(WIRE_COUNT - 1){1'b0}}, 1'b1} << lo_c)
             | ({{(WIRE_COUNT - 1){1'b0}}, 1'b1} << hi_c);

  // start of a new network drops every open layer
  assign count_eff = first_of_network ? '0 : count;

  assign in_ready = (state == cnl_pkg::ST_IDLE);
  assign is_new   = (tgt == count);
  assign hit      = |(rd_data & occ_q);

  cnl_mask_ram #(
    .DEPTH (MAX_LAYERS),
    .WIDTH (WIRE_COUNT),
    .AW    (LW)
  ) u_mask_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (tgt[LW-1:0]),
    .wr_data (wmask)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cnl_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr   <= ptr_next;
    tgt   <= tgt_next;
    prev  <= prev_next;
    wmask <= wmask_next;
    if (in_valid && in_ready) begin
      occ_q <= occ;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ptr_next   = ptr;
    tgt_next   = tgt;
    prev_next  = prev;
    wmask_next = wmask;
    rd_addr    = ptr - LW'(ptr != '0);
    wr_en      = 1'b0;
    out_load   = 1'b0;
    ovf        = 1'b0;
    unique case (state)
      cnl_pkg::ST_IDLE: begin
        // prefetch the newest open layer
        rd_addr = LW'(count_eff - CW'(count_eff != '0));
        if (in_valid) begin
          count_next = count_eff;
          ptr_next   = LW'(count_eff - CW'(count_eff != '0));
          prev_next  = '0;
          if (count_eff == '0) begin
            tgt_next   = '0;
            wmask_next = occ;
            state_next = cnl_pkg::ST_COMMIT;
          end else begin
            state_next = cnl_pkg::ST_SCAN;
          end
        end
      end
      cnl_pkg::ST_SCAN: begin
        // rd_data holds the mask of layer ptr, prev the mask of layer ptr+1
        if (hit) begin
          tgt_next   = CW'(ptr) + CW'(1);
          wmask_next = prev | occ_q;
          state_next = cnl_pkg::ST_COMMIT;
        end else if (ptr == '0) begin
          tgt_next   = '0;
          wmask_next = rd_data | occ_q;
          state_next = cnl_pkg::ST_COMMIT;
        end else begin
          prev_next = rd_data;
          ptr_next  = ptr - LW'(1);
          rd_addr   = ptr - LW'(1);
        end
      end
      cnl_pkg::ST_COMMIT: begin
        if (!out_valid || out_ready) begin
          ovf      = is_new && (count == CW'(MAX_LAYERS));
          wr_en    = !ovf;
          out_load = 1'b1;
          if (is_new && !ovf) begin
            count_next = count + CW'(1);
          end
          state_next = cnl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cnl_pkg::ST_IDLE;
      end
    endcase
  end

  // output register, refilled only once the previous result has gone
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      assigned_layer <= ovf ? '0 : cnl_pkg::LAYER_W'(tgt);
      network_depth  <= cnl_pkg::DEPTH_W'(count_next);
      layer_overflow <= ovf;
    end
  end

endmodule

>>> src/cnl_mask_ram.sv
// layer occupancy mask memory, one write port and one registered read port
`timescale 1ns / 1ps

module cnl_mask_ram #(
  parameter int DEPTH = cnl_pkg::MAX_LAYERS_DEF,
  parameter int WIDTH = cnl_pkg::WIRE_COUNT_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
